/* src/vsde_pkg.sv */
// Package for the voxel sphere density erase block.
// Holds modes, register indexes, widths and fixed-point constants; no dependencies.
package vsde_pkg;

  localparam int AXIS_MAX_DEF = 32;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_ERASE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_SPACING  = 3'd3,
    REG_AXIS     = 3'd4,
    REG_RADIUS   = 3'd5,
    REG_HARDNESS = 3'd6
  } reg_idx_t;

  localparam logic signed [15:0] NEG_ONE_Q12 = -16'sd4096;

  // request from the sweep to the square root unit
  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

endpackage

/* src/vsde_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Depends on vsde_pkg for the request struct.
module vsde_sqrt
  import vsde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sqrt_req_t   req,
  output logic        done,
  output logic [31:0] root
);

  logic [31:0] res;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] part;
  logic [63:0] rad;

  // candidate for the next root bit
  always_comb begin
    trial = {res, 2'b01};
  end

  // bring down two radicand bits and try the next root bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rad  <= req.radicand;
        part <= '0;
        res  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if ({part[31:0], rad[63:62]} >= trial) begin
          part <= {part[31:0], rad[63:62]} - trial;
          res  <= {res[30:0], 1'b1};
        end else begin
          part <= {part[31:0], rad[63:62]};
          res  <= {res[30:0], 1'b0};
        end
        rad <= {rad[61:0], 2'b00};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res;

endmodule

/* src/voxel_sphere_density_erase.sv */
// Top level: voxel density chunk store with a sphere erase brush.
// Depends on vsde_pkg and vsde_sqrt.
//
//  channel | dir | content
//  s_axis  | in  | tdata: voxel_index, density_in, centre_x/y/z; tuser: mode
//  m_axis  | out | tdata: density_out; tuser: affected, dirty
//  cfg     | in  | cfg_index, cfg_data
//
// A write goes from the accept cycle to S_DONE, a read through S_RDWT. An erase
// visits all n^3 voxels; a voxel outside the sphere passes position, squares and
// test, one inside also the square root, depth, multiply and write-back. Reset
// is synchronous and clears control only; the store is undefined until written.
// One request is in work at a time; a result waits in the output register and the
// next request is taken meanwhile.
module voxel_sphere_density_erase
  import vsde_pkg::*;
#(
  parameter int AXIS_MAX = AXIS_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata lsb up: voxel_index[14:0], density_in[30:15], centre_x[54:31],
  // centre_y[78:55], centre_z[102:79], zero fill to 104
  input  logic [103:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: density_out[15:0]
  output logic [15:0]  m_axis_tdata,
  // tuser lsb up: affected[0], dirty[1]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam int AW    = $clog2(AXIS_MAX);
  localparam int DEPTH = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(AXIS_MAX + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDWT  = 9'b000000010,
    S_POS   = 9'b000000100,
    S_SQR   = 9'b000001000,
    S_TEST  = 9'b000010000,
    S_ROOT  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_WB    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [23:0] org_x, org_y, org_z;
  logic [22:0] spacing, radius;
  logic [5:0]  axis_n;
  logic [15:0] hardness;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0; org_y <= '0; org_z <= '0;
      spacing <= 23'd4096; axis_n <= 6'd32;
      radius <= 23'd16384; hardness <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: org_x <= cfg_data;
        REG_ORIGIN_Y: org_y <= cfg_data;
        REG_ORIGIN_Z: org_z <= cfg_data;
        REG_SPACING:  spacing <= cfg_data[22:0];
        REG_AXIS:     axis_n <= cfg_data[5:0];
        REG_RADIUS:   radius <= cfg_data[22:0];
        REG_HARDNESS: hardness <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // density store
  logic signed [15:0] mem [DEPTH];
  logic [IW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [15:0] wr_data, rd_data;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // request hold
  mode_t              mode;
  logic [14:0]        vidx;
  logic signed [23:0] cx, cy, cz;

  // sweep counters and geometry
  logic [CW-1:0] nx, ny, nz, n_eff;
  logic signed [30:0] dx, dy, dz;
  logic signed [61:0] px, py, pz;
  logic [63:0] d2, sq_x, sq_y, sq_z;
  logic [45:0] r2;
  logic [22:0] depth;
  logic [38:0] removal;
  logic        changed, dirty;
  logic [IW-1:0] lin;

  sqrt_req_t   sreq;
  logic        sqrt_start;
  logic        sdone;
  logic [31:0] sroot;

  vsde_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sreq), .done(sdone), .root(sroot));

  assign s_axis_tready = (state == S_IDLE);

  // squared offsets per axis
  assign px = 62'(dx) * 62'(dx);
  assign py = 62'(dy) * 62'(dy);
  assign pz = 62'(dz) * 62'(dz);

  logic signed [17:0] nv;
  logic signed [17:0] nv_c;
  always_comb begin
    nv   = 18'(rd_data) - $signed({2'b0, removal[15:0]});
    nv_c = (removal > 39'd36863 || nv < 18'(NEG_ONE_Q12)) ? 18'(NEG_ONE_Q12) : nv;
  end

  always_comb begin
    lin = IW'((IW+12)'(nz) * (IW+12)'(n_eff) * (IW+12)'(n_eff)
            + (IW+12)'(ny) * (IW+12)'(n_eff) + (IW+12)'(nx));
  end

  logic last_vox;
  assign last_vox = (nx == n_eff - CW'(1)) && (ny == n_eff - CW'(1)) &&
                    (nz == n_eff - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      dirty <= 1'b0;
      wr_en <= 1'b0;
      sqrt_start <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      sqrt_start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            mode <= mode_t'(s_axis_tuser);
            vidx <= s_axis_tdata[14:0];
            cx <= s_axis_tdata[54:31];
            cy <= s_axis_tdata[78:55];
            cz <= s_axis_tdata[102:79];
            rd_addr <= IW'(s_axis_tdata[14:0]);
            changed <= 1'b0;
            nx <= '0; ny <= '0; nz <= '0;
            n_eff <= (int'(axis_n) > AXIS_MAX) ? CW'(AXIS_MAX) : CW'(axis_n);
            r2 <= 46'(radius) * 46'(radius);
            if (s_axis_tuser == MODE_WRITE) begin
              if (32'(s_axis_tdata[14:0]) < DEPTH) begin
                wr_en <= 1'b1;
                wr_addr <= IW'(s_axis_tdata[14:0]);
                wr_data <= s_axis_tdata[30:15];
              end
              state <= S_DONE;
            end else if (s_axis_tuser == MODE_READ) state <= S_RDWT;
            else if (s_axis_tuser == MODE_ERASE) begin
              state <= (axis_n == 6'd0) ? S_DONE : S_POS;
            end else state <= S_DONE;
          end
        end
        S_RDWT: state <= S_DONE;
        S_POS: begin
          dx <= 31'(org_x) + $signed(31'(nx)) * $signed({8'd0, spacing}) - 31'(cx);
          dy <= 31'(org_y) + $signed(31'(ny)) * $signed({8'd0, spacing}) - 31'(cy);
          dz <= 31'(org_z) + $signed(31'(nz)) * $signed({8'd0, spacing}) - 31'(cz);
          rd_addr <= lin;
          state <= S_SQR;
        end
        S_SQR: begin
          sq_x <= 64'(px);
          sq_y <= 64'(py);
          sq_z <= 64'(pz);
          state <= S_TEST;
        end
        S_TEST: begin
          d2 <= sq_x + sq_y + sq_z;
          if (sq_x + sq_y + sq_z >= 64'(r2)) begin
            if (last_vox) state <= S_DONE;
            else state <= S_POS;
            if (nx == n_eff - CW'(1)) begin
              nx <= '0;
              if (ny == n_eff - CW'(1)) begin ny <= '0; nz <= nz + CW'(1); end
              else ny <= ny + CW'(1);
            end else nx <= nx + CW'(1);
          end else begin
            sqrt_start <= 1'b1;
            state <= S_ROOT;
          end
        end
        S_ROOT: if (sdone) begin
          depth <= radius - sroot[22:0];
          state <= S_MUL;
        end
        S_MUL: begin
          removal <= 39'((39'(depth) * 39'(hardness)) >> 12);
          state <= S_WB;
        end
        S_WB: begin
          if (nv_c[15:0] != rd_data) begin
            wr_en <= 1'b1;
            wr_addr <= rd_addr;
            wr_data <= nv_c[15:0];
            changed <= 1'b1;
          end
          if (last_vox) state <= S_DONE;
          else state <= S_POS;
          if (nx == n_eff - CW'(1)) begin
            nx <= '0;
            if (ny == n_eff - CW'(1)) begin ny <= '0; nz <= nz + CW'(1); end
            else ny <= ny + CW'(1);
          end else nx <= nx + CW'(1);
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= (mode == MODE_READ && 32'(vidx) < DEPTH) ? rd_data : 16'd0;
            m_axis_tuser <= {dirty | (mode == MODE_ERASE && changed),
                             mode == MODE_ERASE && changed};
            if (mode == MODE_ERASE && changed) dirty <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sreq = {sqrt_start, d2};

  // affected never shows without dirty
  a_aff_dirty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tuser[0] || m_axis_tuser[1]))
    else $error("affected without dirty");
  // dirty is sticky
  a_dirty_sticky: assert property (@(posedge clk) disable iff (rst)
    dirty |=> dirty) else $error("dirty cleared");
  // stores only happen while working on a request
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(state != S_IDLE || s_axis_tvalid)) else $error("stray write");

endmodule

/* verif/tb.sv */
// Self-checking testbench for voxel_sphere_density_erase: stream driver, monitor and a
// behavioral predictor of the voxel store, the dirty flag and the sphere erase.
// Depends on vsde_pkg and the block's RTL.
module tb;
  import vsde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_N = AXIS_MAX_DEF * AXIS_MAX_DEF * AXIS_MAX_DEF;

  typedef struct {
    mode_t             mode;
    logic [14:0]       vidx;
    logic signed [15:0] dens;
    logic signed [23:0] cx, cy, cz;
  } voxel_req_t;

  typedef struct {
    logic [15:0] dens_out;
    logic        affected;
    logic        dirty;
  } voxel_resp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = MODE_NONE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = REG_ORIGIN_X;
  logic [23:0]  cfg_data = '0;

  voxel_sphere_density_erase dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] voxel_mem [STORE_N];
  bit                 voxel_set [STORE_N];
  int                 set_list [$];
  bit                 dirty_mdl;
  longint             org_x, org_y, org_z;
  longint             spacing_m, axis_m, radius_m, hard_m;

  voxel_req_t  pending_q [$];
  voxel_resp_t result_q [$];
  int          err_cnt = 0;
  int unsigned issued = 0, accepted = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint axis_used();
    return (axis_m > AXIS_MAX_DEF) ? AXIS_MAX_DEF : axis_m;
  endfunction

  function automatic bit in_sphere(longint cx, longint cy, longint cz, int x, int y, int z);
    longint dx, dy, dz;
    dx = org_x + x * spacing_m - cx;
    dy = org_y + y * spacing_m - cy;
    dz = org_z + z * spacing_m - cz;
    return longint'(dx * dx + dy * dy + dz * dz) < radius_m * radius_m;
  endfunction

  // run the sphere erase on the model store, return whether any voxel moved
  function automatic bit erase_model(longint cx, longint cy, longint cz);
    longint n, d2, removal, nv, dx, dy, dz;
    int     i;
    bit     hit = 0;
    n = axis_used();
    for (int z = 0; z < n; z++)
      for (int y = 0; y < n; y++)
        for (int x = 0; x < n; x++) begin
          dx = org_x + x * spacing_m - cx;
          dy = org_y + y * spacing_m - cy;
          dz = org_z + z * spacing_m - cz;
          d2 = dx * dx + dy * dy + dz * dz;
          if (d2 >= radius_m * radius_m) continue;
          i = int'(z * n * n + y * n + x);
          removal = ((radius_m - longint'(root_floor(d2))) * hard_m) >>> 12;
          nv = longint'(voxel_mem[i]) - removal;
          if (nv < -4096) nv = -4096;
          if (nv != longint'(voxel_mem[i])) begin
            voxel_mem[i] = nv[15:0];
            hit = 1;
          end
        end
    if (hit) dirty_mdl = 1;
    return hit;
  endfunction

  // queue one request and its predicted response
  task automatic post_req(voxel_req_t rq);
    voxel_resp_t rs;
    rs = '{dens_out: '0, affected: 1'b0, dirty: 1'b0};
    case (rq.mode)
      MODE_WRITE: begin
        if (!voxel_set[rq.vidx]) set_list.push_back(rq.vidx);
        voxel_set[rq.vidx] = 1;
        voxel_mem[rq.vidx] = rq.dens;
      end
      MODE_READ: rs.dens_out = voxel_mem[rq.vidx];
      MODE_ERASE: rs.affected = erase_model(rq.cx, rq.cy, rq.cz);
      default: ;
    endcase
    rs.dirty = dirty_mdl;
    pending_q.push_back(rq);
    result_q.push_back(rs);
  endtask

  task automatic post_write(int i, logic signed [15:0] d);
    voxel_req_t rq;
    rq = '{mode: MODE_WRITE, vidx: i[14:0], dens: d, cx: $urandom, cy: $urandom,
           cz: $urandom};
    post_req(rq);
  endtask

  task automatic post_read(int i);
    voxel_req_t rq;
    rq = '{mode: MODE_READ, vidx: i[14:0], dens: $urandom, cx: $urandom, cy: $urandom,
           cz: $urandom};
    post_req(rq);
  endtask

  // fill any voxel the sphere would touch that was never written, then erase
  task automatic post_erase(logic signed [23:0] cx, logic signed [23:0] cy,
                            logic signed [23:0] cz);
    voxel_req_t rq;
    longint     n;
    int         i;
    n = axis_used();
    for (int z = 0; z < n; z++)
      for (int y = 0; y < n; y++)
        for (int x = 0; x < n; x++) begin
          i = int'(z * n * n + y * n + x);
          if (!voxel_set[i] && in_sphere(cx, cy, cz, x, y, z))
            post_write(i, $urandom);
        end
    rq = '{mode: MODE_ERASE, vidx: $urandom, dens: $urandom, cx: cx, cy: cy, cz: cz};
    post_req(rq);
  endtask

  task automatic write_reg(reg_idx_t r, logic [23:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (r)
      REG_ORIGIN_X: org_x = longint'($signed(v));
      REG_ORIGIN_Y: org_y = longint'($signed(v));
      REG_ORIGIN_Z: org_z = longint'($signed(v));
      REG_SPACING:  spacing_m = v[22:0];
      REG_AXIS:     axis_m = v[5:0];
      REG_RADIUS:   radius_m = v[22:0];
      default:      hard_m = v[15:0];
    endcase
  endtask

  // hold until every response is back and the block has settled
  task automatic drain();
    while (pending_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_brush(logic [23:0] ox, logic [23:0] oy, logic [23:0] oz,
                           logic [23:0] sp, logic [23:0] n, logic [23:0] rad,
                           logic [23:0] hd);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_SPACING, sp);
    write_reg(REG_AXIS, n);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_HARDNESS, hd);
  endtask

  function automatic logic signed [23:0] near_coord(longint o);
    longint span;
    span = (axis_used() + 1) * spacing_m;
    return 24'(o - spacing_m + longint'($urandom_range(0, 32'(span))));
  endfunction

  // random mix of writes, reads of written voxels, erases near the chunk or anywhere, and idle requests
  task automatic random_phase(int cnt);
    int sel;
    longint n;
    n = axis_used();
    for (int k = 0; k < cnt; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        if ($urandom_range(0, 1) && n > 0)
          post_write($urandom_range(0, 32'(n * n * n - 1)), $urandom);
        else
          post_write($urandom_range(0, STORE_N - 1), $urandom);
      end else if (sel < 65) begin
        if (set_list.size() > 0) post_read(set_list[$urandom_range(0, set_list.size() - 1)]);
      end else if (sel < 85) begin
        post_erase(near_coord(org_x), near_coord(org_y), near_coord(org_z));
      end else if (sel < 90) begin
        post_erase($urandom, $urandom, $urandom);
      end else begin
        post_req('{mode: MODE_NONE, vidx: $urandom, dens: $urandom, cx: $urandom,
                   cy: $urandom, cz: $urandom});
      end
    end
  endtask

  // stimulus sender: bursts of random length separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    voxel_req_t rq;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && issued != accepted) begin
      // hold the request until taken
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      rq = pending_q.pop_front();
      s_axis_tdata  <= {1'b0, rq.cz, rq.cy, rq.cx, rq.dens, rq.vidx};
      s_axis_tuser  <= rq.mode;
      s_axis_tvalid <= 1'b1;
      issued = issued + 1;
      if (burst_left > 0) begin
        burst_left = burst_left - 1;
      end else begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(posedge clk)
    if (s_axis_tvalid && s_axis_tready) accepted <= accepted + 1;

  // response sink: stall percentage redrawn from 0, 30 and 75 on a tick counter
  int stall_pct = 0, stall_tick = 0;
  always @(negedge clk) begin
    stall_tick = stall_tick + 1;
    if (stall_tick % 128 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // compare each response with the oldest prediction
  always @(posedge clk) begin
    voxel_resp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected response: dens %h tuser %b", m_axis_tdata,
                                    m_axis_tuser);
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata !== want.dens_out || m_axis_tuser[0] !== want.affected ||
            m_axis_tuser[1] !== want.dirty) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp dens %h aff %b dirty %b, got dens %h aff %b dirty %b",
                     want.dens_out, want.affected, want.dirty, m_axis_tdata,
                     m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    dirty_mdl = 0;
    org_x = 0; org_y = 0; org_z = 0;
    spacing_m = 4096; axis_m = 32; radius_m = 16384; hard_m = 4096;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: field extremes under reset settings
    post_write(0, 16'sh7FFF);
    post_write(32767, -16'sh8000);
    post_read(0);
    post_read(32767);
    post_req('{mode: MODE_NONE, vidx: '1, dens: '1, cx: '1, cy: '1, cz: '1});
    post_erase(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    post_erase(-24'sh800000, -24'sh800000, -24'sh800000);
    // voxel below -1.0 raised on visit, then full-depth clamp at the centre
    post_write(0, -16'sh8000);
    post_erase(0, 0, 0);
    post_read(0);
    post_read(1);
    post_erase(24'sd40960, 24'sd40960, 24'sd40960);
    post_read(32'd10 * 1024 + 32'd10 * 32 + 32'd10);
    drain();

    // zero hardness and zero radius change nothing; then max radius, then max hardness too
    set_brush(24'd0, 24'd0, 24'd0, 24'd4096, 24'd3, 24'd0, 24'd0);
    post_erase(24'sd4096, 24'sd4096, 24'sd4096);
    drain();
    write_reg(REG_RADIUS, 24'h7FFFFF);
    post_erase(24'sd4096, 24'sd4096, 24'sd4096);
    drain();
    write_reg(REG_HARDNESS, 24'hFFFF);
    write_reg(REG_HARDNESS, 24'hFFFF);
    post_erase(24'sd4096, 24'sd4096, 24'sd4096);
    post_read(13);
    drain();

    // extremes: origins at the ends, spacing zero and max, axis count zero and above max
    set_brush(24'h800000, 24'h7FFFFF, 24'h800000, 24'd0, 24'd2, 24'd8192, 24'd4096);
    post_erase(24'h800000, 24'h7FFFFF, 24'h800000);
    drain();
    set_brush(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'h7FFFFF, 24'hFFFF);
    post_erase(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    random_phase(40);
    drain();
    set_brush(24'd0, 24'd0, 24'd0, 24'd4096, 24'd63, 24'd6000, 24'd2048);
    post_erase(24'sd20480, 24'sd8192, 24'sd61440);
    drain();
    set_brush(24'd0, 24'd0, 24'd0, 24'd4096, 24'd1, 24'd8192, 24'd4096);
    random_phase(40);
    drain();

    // random settings, small chunks
    for (int ph = 0; ph < 10; ph++) begin
      set_brush($urandom, $urandom, $urandom,
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24'h7FFFFF)
                                            : $urandom_range(256, 16384),
                $urandom_range(1, 4), 24'd0, $urandom);
      write_reg(REG_RADIUS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24'h7FFFFF)
                                                        : 32'(spacing_m * $urandom_range(0, 4)));
      random_phase(60);
      drain();
    end

    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
